/* design/cdjd_pkg.sv */
`timescale 1ns / 1ps
// cdjd_pkg: word types, status and register codes, and fixed constants
// for the calendar date to julian day converter. no dependencies.

package cdjd_pkg;

    // input word: one calendar date and time of day
    typedef struct packed {
        logic signed [20:0] year_in;
        logic [3:0]         month_in;
        logic [4:0]         day_in;
        logic [4:0]         hour_in;
        logic [5:0]         minute_in;
        logic [5:0]         second_in;
    } in_word_t;

    // result word: jd = day_whole + 1/2 + seconds_of_day / 86400
    typedef struct packed {
        logic signed [29:0] day_whole;
        logic [16:0]        seconds_of_day;
        logic [2:0]         status;
    } out_word_t;

    // first stage results handed from the prep logic to the pipeline
    typedef struct packed {
        logic [2:0]         status;
        logic signed [34:0] encoded;
        logic signed [20:0] year_adj;
        logic [19:0]        year_abs;
        logic               year_neg;
        logic [8:0]         month_term;
        logic [4:0]         day;
        logic [16:0]        sod;
    } prep_t;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_YEAR   = 3'd1;
    localparam logic [2:0] ST_DAY    = 3'd2;
    localparam logic [2:0] ST_HOUR   = 3'd3;
    localparam logic [2:0] ST_MINUTE = 3'd4;
    localparam logic [2:0] ST_SECOND = 3'd5;
    localparam logic [2:0] ST_MONTH  = 3'd6;
    localparam logic [2:0] ST_GAP    = 3'd7;

    // configuration register indexes
    localparam logic CFG_LAST_OLD  = 1'b0;
    localparam logic CFG_FIRST_NEW = 1'b1;

    localparam int CFG_WIDTH = 35;
    localparam logic signed [CFG_WIDTH-1:0] LAST_OLD_RESET  = 35'sd17520902;
    localparam logic signed [CFG_WIDTH-1:0] FIRST_NEW_RESET = 35'sd17520914;

    // accepted year span is -YEAR_LIMIT .. YEAR_LIMIT
    localparam logic signed [20:0] YEAR_LIMIT = 21'sd1000000;

    localparam logic signed [34:0] YEAR_SCALE  = 35'sd10000;
    localparam logic signed [31:0] DAYS_YEAR   = 32'sd365;
    localparam logic signed [31:0] EPOCH_BASE  = 32'sd1720996;
    localparam logic signed [21:0] JULIAN_OFS  = 22'sd4716;
    localparam logic signed [21:0] JULIAN_BIAS = 22'sd1181;

    // floor(a / 25) = (a * RECIP_25) >> RECIP_SHIFT for a below 493447
    localparam logic [18:0] RECIP_25    = 19'd335545;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [16:0] SECS_HOUR = 17'd3600;
    localparam logic [16:0] SECS_MIN  = 17'd60;

    // floor(30.6001 * (m + 1)) with jan and feb counted as months 13 and 14
    function automatic logic [8:0] month_term(input logic [3:0] month);
        logic [8:0] t;
        case (month)
            4'd1:    t = 9'd428;
            4'd2:    t = 9'd459;
            4'd3:    t = 9'd122;
            4'd4:    t = 9'd153;
            4'd5:    t = 9'd183;
            4'd6:    t = 9'd214;
            4'd7:    t = 9'd244;
            4'd8:    t = 9'd275;
            4'd9:    t = 9'd306;
            4'd10:   t = 9'd336;
            4'd11:   t = 9'd367;
            4'd12:   t = 9'd397;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

endpackage

/* design/cdjd_prep.sv */
`timescale 1ns / 1ps
// cdjd_prep: field range checks, encoded date, shifted year, month term, seconds of day.
// depends on cdjd_pkg.

module cdjd_prep
    import cdjd_pkg::*;
(
    input  in_word_t word,
    output prep_t    prep
);

    logic [2:0]         status;
    logic signed [20:0] year_adj;
    logic               early_month;

    // first failing check wins
    always_comb
    begin
        if (word.year_in < -YEAR_LIMIT || word.year_in > YEAR_LIMIT)
            status = ST_YEAR;
        else if (word.day_in == 5'd0)
            status = ST_DAY;
        else if (word.hour_in > 5'd23)
            status = ST_HOUR;
        else if (word.minute_in > 6'd59)
            status = ST_MINUTE;
        else if (word.second_in > 6'd59)
            status = ST_SECOND;
        else if (!(word.month_in inside {[4'd1:4'd12]}))
            status = ST_MONTH;
        else
            status = ST_OK;
    end

    // jan and feb belong to the previous year
    assign early_month = (word.month_in <= 4'd2);
    assign year_adj    = early_month ? word.year_in - 21'sd1 : word.year_in;

    always_comb
    begin
        prep.status     = status;
        prep.encoded    = 35'(word.year_in) * YEAR_SCALE
                          + $signed(35'(word.month_in) * 35'd100)
                          + $signed(35'(word.day_in));
        prep.year_adj   = year_adj;
        prep.year_neg   = year_adj[20];
        prep.year_abs   = year_adj[20] ? 20'(-year_adj) : 20'(year_adj);
        prep.month_term = month_term(word.month_in);
        prep.day        = word.day_in;
        prep.sod        = 17'(word.hour_in) * SECS_HOUR
                          + 17'(word.minute_in) * SECS_MIN
                          + 17'(word.second_in);
    end

endmodule

/* design/calendar_date_to_julian_day_top.sv */
`timescale 1ns / 1ps
// calendar_date_to_julian_day_top: four stage converter from calendar date
// and time to julian day in fixed point. depends on cdjd_pkg and cdjd_prep.
//
//   channel  signals                      direction  word
//   date     date_valid date_stall date   in         in_word_t
//   jd       jd_valid jd_stall jd         out        out_word_t
//   cfg      cfg_we cfg_index cfg_data    in         35 bit signed date
//
// one word enters per cycle while date_stall is low; each result passes
// the input register, then the prep, select and result registers in that
// order before it appears on jd
// reset clears all stage valids and loads the default calendar switch
// dates (1752-09-02 and 1752-09-14); no clearing pass is needed
// a stall on jd freezes only the stages that are full, so bubbles close
// up and date_stall rises only when every stage holds a word

module calendar_date_to_julian_day_top
    import cdjd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        date_valid,
    output logic                        date_stall,
    input  in_word_t                    date,
    output logic                        jd_valid,
    input  logic                        jd_stall,
    output out_word_t                   jd,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic signed [CFG_WIDTH-1:0] cfg_data
);

    // calendar switch registers
    logic signed [CFG_WIDTH-1:0] last_old_reg;
    logic signed [CFG_WIDTH-1:0] first_new_reg;

    // stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en;

    // stage 1: raw input word
    in_word_t s1_word_reg;

    // stage 2: checked and prepared fields
    prep_t s2_prep_next, s2_prep_reg;

    // stage 3: calendar selection, divisions and base sum
    logic [2:0]         s3_status_next, s3_status_reg;
    logic               s3_julian_next, s3_julian_reg;
    logic signed [31:0] s3_base_next, s3_base_reg;
    logic signed [21:0] s3_jterm_next, s3_jterm_reg;
    logic [18:0]        s3_gsum_next, s3_gsum_reg;
    logic               s3_neg_reg;
    logic [16:0]        s3_sod_reg;

    // stage 4: result word
    out_word_t s4_word_next, s4_word_reg;

    // stage 2 to 3 helpers
    logic               on_old, on_new;
    logic [17:0]        quarter;
    logic [36:0]        recip_prod;
    logic [13:0]        q100;
    logic signed [21:0] jul_num, jul_quot;

    // stage 3 to 4 helpers
    logic signed [31:0] term, whole;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_old_reg  <= LAST_OLD_RESET;
            first_new_reg <= FIRST_NEW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAST_OLD:  last_old_reg  <= cfg_data;
                CFG_FIRST_NEW: first_new_reg <= cfg_data;
                default:       last_old_reg  <= last_old_reg;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // a stage loads when it is empty or its word moves on
    assign s4_en      = !s4_valid_reg || !jd_stall;
    assign s3_en      = !s3_valid_reg || s4_en;
    assign s2_en      = !s2_valid_reg || s3_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign date_stall = !s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= date_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 1 to 2 ----------------
    cdjd_prep u_prep
    (
        .word (s1_word_reg),
        .prep (s2_prep_next)
    );

    // ---------------- stage 2 to 3 ----------------
    // calendar choice; the julian test wins when the registers overlap
    assign on_old = (s2_prep_reg.encoded <= last_old_reg);
    assign on_new = (s2_prep_reg.encoded >= first_new_reg);

    always_comb
    begin
        if (s2_prep_reg.status != ST_OK)
            s3_status_next = s2_prep_reg.status;
        else if (!on_old && !on_new)
            s3_status_next = ST_GAP;
        else
            s3_status_next = ST_OK;
    end
    assign s3_julian_next = on_old;

    // gregorian divisions on the magnitude: |y|/4, |y|/100, |y|/400
    assign quarter      = s2_prep_reg.year_abs[19:2];
    assign recip_prod   = 37'(quarter) * 37'(RECIP_25);
    assign q100         = recip_prod[RECIP_SHIFT +: 14];
    assign s3_gsum_next = 19'(quarter) + 19'(q100[13:2]) - 19'(q100);

    // julian term, (y + 4716) / 4 rounded toward zero
    assign jul_num       = 22'(s2_prep_reg.year_adj) + JULIAN_OFS;
    assign jul_quot      = jul_num[21] ? (jul_num + 22'sd3) >>> 2 : jul_num >>> 2;
    assign s3_jterm_next = jul_quot - JULIAN_BIAS;

    assign s3_base_next = 32'(s2_prep_reg.year_adj) * DAYS_YEAR + EPOCH_BASE
                          + $signed(32'(s2_prep_reg.month_term))
                          + $signed(32'(s2_prep_reg.day));

    // ---------------- stage 3 to 4 ----------------
    always_comb
    begin
        if (s3_julian_reg)
            term = 32'(s3_jterm_reg);
        else if (s3_neg_reg)
            term = -$signed(32'(s3_gsum_reg));
        else
            term = $signed(32'(s3_gsum_reg));
    end
    assign whole = s3_base_reg + term;

    always_comb
    begin
        s4_word_next.status = s3_status_reg;
        if (s3_status_reg == ST_OK)
        begin
            s4_word_next.day_whole      = whole[29:0];
            s4_word_next.seconds_of_day = s3_sod_reg;
        end
        else
        begin
            s4_word_next.day_whole      = '0;
            s4_word_next.seconds_of_day = '0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (s1_en)
            s1_word_reg <= date;
        if (s2_en)
            s2_prep_reg <= s2_prep_next;
        if (s3_en)
        begin
            s3_status_reg <= s3_status_next;
            s3_julian_reg <= s3_julian_next;
            s3_base_reg   <= s3_base_next;
            s3_jterm_reg  <= s3_jterm_next;
            s3_gsum_reg   <= s3_gsum_next;
            s3_neg_reg    <= s2_prep_reg.year_neg;
            s3_sod_reg    <= s2_prep_reg.sod;
        end
        if (s4_en)
            s4_word_reg <= s4_word_next;
    end

    assign jd_valid = s4_valid_reg;
    assign jd       = s4_word_reg;

endmodule

/* design/cdjd_checker.sv */
`timescale 1ns / 1ps
// cdjd_checker: port level assertions for the julian day converter, bound
// to the top level. depends on cdjd_pkg.

module cdjd_checker
    import cdjd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      date_valid,
    input logic      date_stall,
    input logic      jd_valid,
    input logic      jd_stall,
    input out_word_t jd
);

    // words taken but not yet delivered
    logic [2:0] inflight_reg, inflight_next;
    logic       take_in, take_out;

    assign take_in  = date_valid && !date_stall;
    assign take_out = jd_valid && !jd_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (take_in && !take_out)
            inflight_next = inflight_reg + 3'd1;
        else if (take_out && !take_in)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        jd_valid && jd_stall |=> jd_valid && $stable(jd))
        else $error("result word changed under stall");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        jd_valid |-> inflight_reg != 3'd0)
        else $error("result word with no word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        jd_valid && jd.status != ST_OK |->
            jd.day_whole == 30'sd0 && jd.seconds_of_day == 17'd0)
        else $error("error result carries nonzero fields");

    a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
        jd_valid |-> jd.seconds_of_day < 17'd86400)
        else $error("seconds of day out of range");

endmodule

bind calendar_date_to_julian_day_top cdjd_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .date_valid (date_valid),
    .date_stall (date_stall),
    .jd_valid   (jd_valid),
    .jd_stall   (jd_stall),
    .jd         (jd)
);

/* tb/sv/jd_check_pkg.sv */
`timescale 1ns / 1ps
// jd_check_pkg: expected julian day words and their comparison with the
// converter output. depends on cdjd_pkg for word types and status codes.

package jd_check_pkg;
    import cdjd_pkg::*;

    class jd_tally;
        logic signed [CFG_WIDTH-1:0] last_old  = LAST_OLD_RESET;
        logic signed [CFG_WIDTH-1:0] first_new = FIRST_NEW_RESET;
        out_word_t pending_jd[$];
        int unsigned errors;

        // fixed point julian day of one date word under the current switch dates
        function out_word_t julian_day_of(in_word_t w);
            out_word_t r;
            longint yr;
            longint mo;
            longint dy;
            longint hr;
            longint mi;
            longint se;
            longint enc;
            longint term;
            longint whole;
            r = '0;
            yr = w.year_in;
            mo = w.month_in;
            dy = w.day_in;
            hr = w.hour_in;
            mi = w.minute_in;
            se = w.second_in;
            if (yr < -longint'(YEAR_LIMIT) || yr > longint'(YEAR_LIMIT))
                r.status = ST_YEAR;
            else if (dy < 1 || dy > 31)
                r.status = ST_DAY;
            else if (hr > 23)
                r.status = ST_HOUR;
            else if (mi > 59)
                r.status = ST_MINUTE;
            else if (se > 59)
                r.status = ST_SECOND;
            else if (mo < 1 || mo > 12)
                r.status = ST_MONTH;
            else
            begin
                enc = yr * 10000 + mo * 100 + dy;
                // jan and feb belong to the previous year
                if (mo <= 2)
                begin
                    mo += 12;
                    yr -= 1;
                end
                // old style wins when the two dates overlap
                if (enc <= longint'(last_old))
                    term = -2 + (yr + 4716) / 4 - 1179;
                else if (enc >= longint'(first_new))
                    term = yr / 400 - yr / 100 + yr / 4;
                else
                    r.status = ST_GAP;
                if (r.status == ST_OK)
                begin
                    whole = 365 * yr + 1720996 + term + (306001 * (mo + 1)) / 10000 + dy;
                    r.day_whole = whole[29:0];
                    r.seconds_of_day = 17'(hr * 3600 + mi * 60 + se);
                end
            end
            return r;
        endfunction

        function void take_date(in_word_t w);
            pending_jd.push_back(julian_day_of(w));
        endfunction

        function int waiting();
            return pending_jd.size();
        endfunction

        function void report(string field, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_jd(out_word_t got);
            out_word_t want;
            if (pending_jd.size() == 0)
            begin
                errors++;
                $display("%0t: jd word with nothing pending, expected none, actual %0d/%0d/%0d",
                         $time, got.day_whole, got.seconds_of_day, got.status);
                return;
            end
            want = pending_jd.pop_front();
            if (got.day_whole !== want.day_whole)
                report("day_whole", want.day_whole, got.day_whole);
            if (got.seconds_of_day !== want.seconds_of_day)
                report("seconds_of_day", want.seconds_of_day, got.seconds_of_day);
            if (got.status !== want.status)
                report("status", want.status, got.status);
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: random and directed test of calendar_date_to_julian_day_top,
// with idle bursts on both channels. depends on cdjd_pkg and jd_check_pkg.

module tb_top;
    import cdjd_pkg::*;
    import jd_check_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 166;

    localparam logic signed [CFG_WIDTH-1:0] CFG_MIN = -35'sd10000000000;
    localparam logic signed [CFG_WIDTH-1:0] CFG_MAX = 35'sd10000000000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        date_valid;
    logic                        date_stall;
    in_word_t                    date;
    logic                        jd_valid;
    logic                        jd_stall;
    out_word_t                   jd;
    logic                        cfg_we;
    logic                        cfg_index;
    logic signed [CFG_WIDTH-1:0] cfg_data;

    jd_tally tally = new();

    // chance of an idle burst is one in this many words (gap_odds) or clocks (stall_odds); zero means never
    int gap_odds   = 0;
    int stall_odds = 0;
    int cycles     = 0;

    // switch dates per phase: defaults, 1582 reform, overlap, extremes,
    // full range, and back to defaults for the quiet tail
    logic signed [CFG_WIDTH-1:0] old_dates[PHASES] = '{
        LAST_OLD_RESET, 35'sd15821004, 35'sd30000000, CFG_MIN,
        CFG_MAX, CFG_MIN, -35'sd10000000000, LAST_OLD_RESET};
    logic signed [CFG_WIDTH-1:0] new_dates[PHASES] = '{
        FIRST_NEW_RESET, 35'sd15821015, -35'sd20000000, CFG_MAX,
        CFG_MAX, CFG_MIN, 35'sd10000000000, FIRST_NEW_RESET};

    calendar_date_to_julian_day_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .date_valid (date_valid),
        .date_stall (date_stall),
        .date       (date),
        .jd_valid   (jd_valid),
        .jd_stall   (jd_stall),
        .jd         (jd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: inputs change only at rising edges, so the falling edge
    // sees exactly what the next rising edge will take
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && jd_valid === 1'b1 && jd_stall === 1'b0)
            tally.check_jd(jd);
    end

    // receiver stall bursts
    initial
    begin
        jd_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                jd_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                jd_stall <= 1'b0;
            end
        end
    end

    function automatic in_word_t mk(input int y, input int mo, input int d,
                                    input int h, input int mi, input int s);
        in_word_t w;
        w.year_in   = y[20:0];
        w.month_in  = mo[3:0];
        w.day_in    = d[4:0];
        w.hour_in   = h[4:0];
        w.minute_in = mi[5:0];
        w.second_in = s[5:0];
        return w;
    endfunction

    // mostly well formed dates, some with one field out of range, some noise
    function automatic in_word_t rand_date();
        in_word_t w;
        logic [63:0] raw;
        longint sw;
        int y;
        int pick;
        raw = {$urandom, $urandom};
        w = raw[46:0];
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return w;
        case ($urandom_range(0, 3))
            0:
            begin
                // near the old style switch date so the gap gets hit
                sw = longint'(tally.last_old) / 10000 + longint'($urandom_range(0, 6)) - 3;
                if (sw > 1000000)
                    sw = 1000000;
                if (sw < -1000000)
                    sw = -1000000;
                y = int'(sw);
            end
            1: y = int'($urandom_range(0, 10000)) - 5000;
            2: y = int'($urandom_range(0, 2000000)) - 1000000;
            default:
            begin
                y = 1000000 - int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    y = -y;
            end
        endcase
        w = mk(y, $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
               $urandom_range(0, 59), $urandom_range(0, 59));
        if (pick == 1)
        begin
            // push one field past its range
            case ($urandom_range(0, 5))
                0:
                begin
                    y = int'($urandom_range(1000001, 1048575));
                    if ($urandom_range(0, 1) == 1)
                        y = -y;
                    w.year_in = y[20:0];
                end
                1: w.day_in = 5'd0;
                2: w.hour_in = 5'($urandom_range(24, 31));
                3: w.minute_in = 6'($urandom_range(60, 63));
                4: w.second_in = 6'($urandom_range(60, 63));
                default: w.month_in = ($urandom_range(0, 1) == 1) ? 4'd0
                                                                  : 4'($urandom_range(13, 15));
            endcase
        end
        return w;
    endfunction

    // offer one date word and hold it until taken
    task automatic send_date(input in_word_t w);
        bit took;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            date_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        date_valid <= 1'b1;
        date       <= w;
        do
        begin
            @(negedge clk);
            took = (date_stall === 1'b0);
            if (took)
                tally.take_date(w);
            @(posedge clk);
        end
        while (!took);
    endtask

    // stop offering, wait for every result, then let the pipeline run dry
    task automatic settle();
        date_valid <= 1'b0;
        while (tally.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_switch_dates(input logic signed [CFG_WIDTH-1:0] last_old,
                                    input logic signed [CFG_WIDTH-1:0] first_new);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LAST_OLD;
        cfg_data  <= last_old;
        @(posedge clk);
        cfg_index <= CFG_FIRST_NEW;
        cfg_data  <= first_new;
        @(posedge clk);
        cfg_we          <= 1'b0;
        tally.last_old  = last_old;
        tally.first_new = first_new;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        date_valid = 1'b0;
        date       = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_LAST_OLD;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset switch dates
        send_date(mk(2000, 1, 1, 12, 0, 0));           // j2000 noon
        send_date(mk(1752, 9, 2, 23, 59, 59));         // last old style day
        send_date(mk(1752, 9, 3, 0, 0, 0));            // first day in gap
        send_date(mk(1752, 9, 13, 12, 30, 30));        // last day in gap
        send_date(mk(1752, 9, 14, 0, 0, 0));           // first new style day
        send_date(mk(-1000000, 1, 1, 0, 0, 0));        // lowest year
        send_date(mk(1000000, 12, 31, 23, 59, 59));    // highest year, last second
        send_date(mk(-1000001, 6, 15, 1, 2, 3));       // year just below range
        send_date(mk(1000001, 6, 15, 1, 2, 3));        // year just above range
        send_date(mk(-1048576, 0, 0, 31, 63, 63));     // every field bad, year first
        send_date(mk(1048575, 15, 31, 24, 60, 60));    // top year code
        send_date(mk(2020, 5, 0, 31, 0, 0));           // day zero beats bad hour
        send_date(mk(2020, 5, 10, 24, 63, 0));         // hour beats minute
        send_date(mk(2020, 0, 10, 5, 60, 63));         // minute beats second, month
        send_date(mk(2020, 15, 10, 5, 6, 63));         // second beats month
        send_date(mk(2020, 0, 10, 5, 6, 7));           // month zero
        send_date(mk(2020, 13, 10, 5, 6, 7));          // month thirteen
        send_date(mk(2023, 2, 31, 6, 0, 0));           // impossible day, counted on
        send_date(mk(-1, 1, 1, 0, 0, 1));              // negative year after shift
        send_date(mk(-4713, 1, 1, 12, 0, 0));          // one year before julian day zero
        send_date(mk(1600, 2, 29, 18, 45, 15));        // old style leap day
        send_date(mk(0, 3, 1, 0, 0, 0));               // year zero, march
        send_date(mk(-101, 12, 31, 23, 0, 0));         // negative year, no shift

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                set_switch_dates(old_dates[p], new_dates[p]);
            end
            // last phase runs with both sides always ready
            if (p == PHASES - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(2, 10));
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(2, 10));
            end
            for (int i = 0; i < PHASE_WORDS; i++)
                send_date(rand_date());
        end

        settle();
        if (tally.errors == 0 && tally.waiting() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
